FILE: rtl/bosd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bosd_pkg;

	localparam int OFFSET_BITS_DEFAULT = 32;

	localparam int WORD_W   = 16;
	localparam int OFFSET_W = 32;
	localparam int ELEM_W   = 4;
	localparam int COUNT_W  = 7;
	localparam int SEEN_W   = 15;
	localparam int RUN_W    = 15;

	localparam int TYPE_SHIFT       = 13;
	localparam int LOOPS_SHIFT      = 7;
	localparam int SKIP_BLOCK_SHIFT = 8;
	localparam int LARGEST_TYPE     = 3;

	typedef enum logic [2:0] {
		ST_SWAP     = 3'd0,
		ST_SKIP     = 3'd1,
		ST_END      = 3'd2,
		ST_BADTYPE  = 3'd3,
		ST_ODD      = 3'd4,
		ST_NOTERM   = 3'd5,
		ST_OVERFLOW = 3'd6,
		ST_IGNORED  = 3'd7
	} status_t;

	typedef struct packed {
		status_t               status;
		logic [OFFSET_W-1:0]   offset;
		logic [ELEM_W-1:0]     element_bytes;
		logic [COUNT_W-1:0]    count;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/bosd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bosd_core #(
	parameter int OFFSET_BITS = bosd_pkg::OFFSET_BITS_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire logic [bosd_pkg::WORD_W-1:0]   word,
	input  wire logic [bosd_pkg::WORD_W-1:0]   script_bytes,
	output bosd_pkg::result_t                  result
);

	localparam int EXT_W = (OFFSET_BITS > bosd_pkg::OFFSET_W) ? OFFSET_BITS
		: bosd_pkg::OFFSET_W;

	logic [OFFSET_BITS-1:0]            cursor_q;
	logic [bosd_pkg::SEEN_W-1:0]       words_seen_q;
	logic                              finished_q;

	logic [bosd_pkg::WORD_W-bosd_pkg::TYPE_SHIFT-1:0]          wtype;
	logic [bosd_pkg::TYPE_SHIFT-bosd_pkg::LOOPS_SHIFT-1:0]     loops;
	logic [bosd_pkg::LOOPS_SHIFT-1:0]                          skip;
	logic [bosd_pkg::SEEN_W-1:0]       nwords;
	logic [bosd_pkg::SEEN_W:0]         idx_next;
	logic [OFFSET_BITS:0]              pos_full;
	logic [OFFSET_BITS:0]              end_full;
	logic [OFFSET_BITS-1:0]            pos;
	logic [bosd_pkg::RUN_W-1:0]        run_bytes;
	logic [EXT_W-1:0]                  pos_ext;
	logic                              keeps_going;

	always_comb begin
		wtype    = word[bosd_pkg::WORD_W-1:bosd_pkg::TYPE_SHIFT];
		loops    = word[bosd_pkg::TYPE_SHIFT-1:bosd_pkg::LOOPS_SHIFT];
		skip     = word[bosd_pkg::LOOPS_SHIFT-1:0];
		nwords   = script_bytes[bosd_pkg::WORD_W-1:1];
		idx_next = (bosd_pkg::SEEN_W+1)'(words_seen_q) + (bosd_pkg::SEEN_W+1)'(1);

		pos_full = (OFFSET_BITS+1)'(cursor_q) + (OFFSET_BITS+1)'({skip, 1'b0});
		pos      = pos_full[OFFSET_BITS-1:0];
		if (wtype == '0) begin
			run_bytes = bosd_pkg::RUN_W'(loops) << bosd_pkg::SKIP_BLOCK_SHIFT;
		end else begin
			run_bytes = (bosd_pkg::RUN_W'(loops) + bosd_pkg::RUN_W'(1)) << wtype;
		end
		end_full = (OFFSET_BITS+1)'(pos) + (OFFSET_BITS+1)'(run_bytes);
		pos_ext  = EXT_W'(pos);

		result = '0;
		priority if (finished_q) begin
			result.status = bosd_pkg::ST_IGNORED;
		end else if (script_bytes[0]) begin
			result.status = bosd_pkg::ST_ODD;
		end else if (words_seen_q >= nwords) begin
			result.status = bosd_pkg::ST_NOTERM;
		end else if (word == '0) begin
			result.status = bosd_pkg::ST_END;
		end else if (wtype > 3'(bosd_pkg::LARGEST_TYPE)) begin
			result.status = bosd_pkg::ST_BADTYPE;
		end else if (pos_full[OFFSET_BITS] || end_full[OFFSET_BITS]) begin
			result.status = bosd_pkg::ST_OVERFLOW;
		end else if (idx_next == {1'b0, nwords}) begin
			result.status = bosd_pkg::ST_NOTERM;
		end else if (wtype == '0) begin
			result.status = bosd_pkg::ST_SKIP;
		end else begin
			result.status        = bosd_pkg::ST_SWAP;
			result.offset        = pos_ext[bosd_pkg::OFFSET_W-1:0];
			result.element_bytes = bosd_pkg::ELEM_W'(1) << wtype;
			result.count         = bosd_pkg::COUNT_W'(loops) + bosd_pkg::COUNT_W'(1);
		end

		keeps_going = (result.status == bosd_pkg::ST_SWAP)
			|| (result.status == bosd_pkg::ST_SKIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q     <= '0;
			words_seen_q <= '0;
			finished_q   <= 1'b0;
		end else if (fire && !finished_q) begin
			words_seen_q <= idx_next[bosd_pkg::SEEN_W-1:0];
			if (keeps_going) begin
				cursor_q <= end_full[OFFSET_BITS-1:0];
			end else begin
				finished_q <= 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_ignored_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> result.status == bosd_pkg::ST_IGNORED)
		else $error("A word after the end of the script was not ignored.");

	a_finish_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !keeps_going |=> finished_q)
		else $error("A terminating status did not set the finished flag.");

	a_cursor_held: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !keeps_going |=> cursor_q == $past(cursor_q))
		else $error("The cursor moved on a terminating status.");

	a_swap_size: assert property (@(posedge clk) disable iff (!arst_n)
		result.status == bosd_pkg::ST_SWAP |-> result.element_bytes == 4'd2
			|| result.element_bytes == 4'd4 || result.element_bytes == 4'd8)
		else $error("A swap record carries an illegal element size.");

	a_empty_record: assert property (@(posedge clk) disable iff (!arst_n)
		result.status != bosd_pkg::ST_SWAP |-> result.offset == '0
			&& result.element_bytes == '0 && result.count == '0)
		else $error("A non-swap status carries record fields.");
`endif

endmodule

`default_nettype wire

FILE: rtl/byte_order_script_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes a byte order script one 16-bit word per beat and returns exactly one result
// beat per word: a swap record, a skip, the end of the script or an error status. The
// block takes one word per clock cycle while out_ready is high; a word is registered in word_s1,
// decoded and registered as a result in res_s2. The rate is set by the cursor update, one add for
// the skip and one add and overflow check for the run, which closes on the cursor register. Write
// script_bytes before the first word; after the end of the script or an error every
// further word answers as ignored until reset.
module byte_order_script_decoder #(
	parameter int OFFSET_BITS = bosd_pkg::OFFSET_BITS_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          script_bytes_we,
	input  wire logic [bosd_pkg::WORD_W-1:0]   script_bytes,

	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [bosd_pkg::WORD_W-1:0]   word,

	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [2:0]                         status,
	output logic [bosd_pkg::OFFSET_W-1:0]      offset,
	output logic [bosd_pkg::ELEM_W-1:0]        element_bytes,
	output logic [bosd_pkg::COUNT_W-1:0]       count
);

	logic [bosd_pkg::WORD_W-1:0]  script_bytes_q;
	logic [bosd_pkg::WORD_W-1:0]  word_s1;
	logic                         valid_s1;
	bosd_pkg::result_t            res_s2;
	logic                         valid_s2;
	bosd_pkg::result_t            res_next;
	logic                         load_s2;
	logic                         fire;

	assign load_s2  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && load_s2;
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			script_bytes_q <= '0;
		end else if (script_bytes_we) begin
			script_bytes_q <= script_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= fire;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_s1 <= '0;
			res_s2  <= '0;
		end else begin
			if (in_ready && in_valid) begin
				word_s1 <= word;
			end
			if (fire) begin
				res_s2 <= res_next;
			end
		end
	end

	bosd_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.word         (word_s1),
		.script_bytes (script_bytes_q),
		.result       (res_next)
	);

	assign out_valid     = valid_s2;
	assign status        = res_s2.status;
	assign offset        = res_s2.offset;
	assign element_bytes = res_s2.element_bytes;
	assign count         = res_s2.count;

endmodule

`default_nettype wire

FILE: test/byte_order_script_decoder_test.sv
`timescale 1ns / 1ps

module byte_order_script_decoder_test;

	localparam int CURSOR_BITS = bosd_pkg::OFFSET_BITS_DEFAULT;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_WORDS = 275;

	class script_scoreboard;
		bit [15:0] script_len = '0;
		bit [63:0] cursor = '0;
		bit [14:0] words_seen = '0;
		bit done = 1'b0;
		bosd_pkg::result_t expected_q[$];
		int errors = 0;

		function void set_length(bit [15:0] v);
			script_len = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function bosd_pkg::result_t decode(bit [15:0] w);
			bosd_pkg::result_t r;
			bit [63:0] limit;
			bit [63:0] pos;
			bit [63:0] add;
			int idx;
			int nwords;
			bit [2:0] kind;
			bit [5:0] loops;
			bit [6:0] skip;
			r = '0;
			limit = (64'd1 << CURSOR_BITS) - 64'd1;
			idx = words_seen;
			nwords = script_len >> 1;
			kind = w[15:13];
			loops = w[12:7];
			skip = w[6:0];
			if (done) begin
				r.status = bosd_pkg::ST_IGNORED;
				return r;
			end
			words_seen = words_seen + 15'd1;
			done = 1'b1;
			if (script_len[0]) begin
				r.status = bosd_pkg::ST_ODD;
				return r;
			end
			if (idx >= nwords) begin
				r.status = bosd_pkg::ST_NOTERM;
				return r;
			end
			if (w == 16'd0) begin
				r.status = bosd_pkg::ST_END;
				return r;
			end
			if (kind > bosd_pkg::LARGEST_TYPE) begin
				r.status = bosd_pkg::ST_BADTYPE;
				return r;
			end
			add = 64'(skip) * 64'd2;
			if (add > limit - cursor) begin
				r.status = bosd_pkg::ST_OVERFLOW;
				return r;
			end
			pos = cursor + add;
			if (kind == 3'd0)
				add = 64'(loops) << bosd_pkg::SKIP_BLOCK_SHIFT;
			else
				add = (64'd1 << kind) * (64'(loops) + 64'd1);
			if (add > limit - pos) begin
				r.status = bosd_pkg::ST_OVERFLOW;
				return r;
			end
			if (idx + 1 == nwords) begin
				r.status = bosd_pkg::ST_NOTERM;
				return r;
			end
			done = 1'b0;
			cursor = pos + add;
			if (kind == 3'd0) begin
				r.status = bosd_pkg::ST_SKIP;
				return r;
			end
			r.status = bosd_pkg::ST_SWAP;
			r.offset = pos[bosd_pkg::OFFSET_W-1:0];
			r.element_bytes = bosd_pkg::ELEM_W'(1 << kind);
			r.count = bosd_pkg::COUNT_W'(loops) + bosd_pkg::COUNT_W'(1);
			return r;
		endfunction

		function void note_word(bit [15:0] w);
			expected_q.insert(expected_q.size(), decode(w));
		endfunction

		function void check_result(bosd_pkg::result_t got);
			bosd_pkg::result_t exp;
			if (expected_q.size() == 0) begin
				if (errors < 10)
					$display("%0t: unexpected result beat: status %0d offset %h size %0d count %0d",
						$realtime, got.status, got.offset, got.element_bytes, got.count);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			if (exp.status != got.status || exp.offset != got.offset ||
					exp.element_bytes != got.element_bytes || exp.count != got.count) begin
				if (errors < 10)
					$display("%0t: mismatch: status %0d/%0d offset %h/%h size %0d/%0d count %0d/%0d",
						$realtime, exp.status, got.status, exp.offset, got.offset,
						exp.element_bytes, got.element_bytes, exp.count, got.count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic script_bytes_we;
	logic [bosd_pkg::WORD_W-1:0] script_bytes;
	logic in_valid;
	logic in_ready;
	logic [bosd_pkg::WORD_W-1:0] word;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [bosd_pkg::OFFSET_W-1:0] offset;
	logic [bosd_pkg::ELEM_W-1:0] element_bytes;
	logic [bosd_pkg::COUNT_W-1:0] count;

	script_scoreboard sb = new();
	bit steady = 1'b0;
	int cycle_count = 0;
	int stall_left = 0;
	int ready_gap;
	int idle_cycles = 0;

	bit [15:0] directed_words [14] = '{
		16'h0001, 16'h1FFF, 16'h0080, 16'h2000, 16'h3FFF, 16'h4000, 16'h5FFF,
		16'h6000, 16'h7FFF, 16'h007F, 16'h1F80, 16'h2A55, 16'h55AA, 16'h6B2D
	};

	byte_order_script_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.script_bytes_we(script_bytes_we),
		.script_bytes(script_bytes),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.word(word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.offset(offset),
		.element_bytes(element_bytes),
		.count(count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic bit [15:0] random_script_word();
		bit [2:0] kind;
		bit [5:0] loops;
		bit [6:0] skip;
		int r;
		kind = $urandom_range(0, bosd_pkg::LARGEST_TYPE);
		r = $urandom_range(0, 9);
		loops = (r == 0) ? 6'd0 : (r == 1) ? 6'd63 : 6'($urandom_range(0, 63));
		r = $urandom_range(0, 9);
		skip = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : 7'($urandom_range(0, 127));
		if (kind == 3'd0 && loops == 6'd0 && skip == 7'd0)
			skip = 7'd1;
		return {kind, loops, skip};
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 200 == 0)
			steady <= ($urandom_range(0, 3) == 0);
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			ready_gap = pick_gap();
			if (ready_gap == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall_left = ready_gap - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{bosd_pkg::status_t'(status), offset, element_bytes, count});
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_word(input bit [15:0] w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		word <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_word(w);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(input int v);
		drain();
		script_bytes_we <= 1'b1;
		script_bytes <= v[15:0];
		sb.set_length(v[15:0]);
		@(posedge clk);
		script_bytes_we <= 1'b0;
	endtask

	task automatic send_random_words(input int n);
		repeat (n) send_word(random_script_word());
	endtask

	initial begin
		int end_kind;
		arst_n = 1'b0;
		script_bytes_we = 1'b0;
		script_bytes = '0;
		in_valid = 1'b0;
		word = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_length(16'hFFFE);
		foreach (directed_words[i])
			send_word(directed_words[i]);

		write_length(2 * (sb.words_seen + PHASE_WORDS + $urandom_range(1, 1000)));
		send_random_words(PHASE_WORDS);
		write_length(16'hFFFE);
		send_random_words(PHASE_WORDS);
		write_length(2 * (sb.words_seen + PHASE_WORDS + 1));
		send_random_words(PHASE_WORDS);
		write_length(2 * (sb.words_seen + PHASE_WORDS + $urandom_range(1, 50)));
		send_random_words(PHASE_WORDS);

		// The script can finish only once per reset, so one way of ending it is picked.
		end_kind = $urandom_range(0, 4);
		case (end_kind)
			0: begin
				write_length($urandom_range(0, 1) ? 16'hFFFF : 2 * $urandom_range(0, 30000) + 1);
				send_word(random_script_word());
			end
			1: begin
				write_length($urandom_range(0, 1) ? 0 : 2 * sb.words_seen);
				send_word(random_script_word());
			end
			2: begin
				send_word(16'h0000);
			end
			3: begin
				send_word({3'($urandom_range(4, 7)), 13'($urandom_range(0, 8191))});
			end
			default: begin
				write_length(2 * (sb.words_seen + 1));
				send_word(random_script_word());
			end
		endcase

		repeat (20) send_word(16'($urandom_range(0, 65535)));
		write_length(0);
		send_word(16'h0000);
		send_word(16'hFFFF);
		write_length(16'hFFFF);
		repeat (20) send_word(16'($urandom_range(0, 65535)));

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/bosd_pkg.sv
rtl/bosd_core.sv
rtl/byte_order_script_decoder.sv
test/byte_order_script_decoder_test.sv
